// ===== sv/rce_pkg.sv =====
package rce_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SEARCH = 2'd1,
		OP_READ   = 2'd2,
		OP_REARM  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SEEK_INVALID = 2'd0,
		SEEK_ABOVE   = 2'd1,
		SEEK_BELOW   = 2'd2
	} seek_t;

	typedef enum logic [1:0] {
		TRIG_OFF       = 2'd0,
		TRIG_RISING    = 2'd1,
		TRIG_FALLING   = 2'd2,
		TRIG_SEEK_ONLY = 2'd3
	} trig_mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_START,
		ST_WALK,
		ST_READ,
		ST_READ_OUT
	} state_t;

	localparam logic [2:0] CFG_TRIGGER_MODE  = 3'd0;
	localparam logic [2:0] CFG_TRIGGER_LEVEL = 3'd1;
	localparam logic [2:0] CFG_LEVEL_OFFSET  = 3'd2;
	localparam logic [2:0] CFG_HYSTERESIS    = 3'd3;
	localparam logic [2:0] CFG_SINGLE_SHOT   = 3'd4;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] sample;
		logic [13:0]        delay;
		logic [14:0]        window;
		logic [13:0]        read_address;
	} item_t;

	typedef struct packed {
		logic [13:0]        write_slot;
		logic               write_triggered;
		logic [14:0]        result_delay;
		logic               found;
		logic               single_shot_hit;
		logic [13:0]        trigger_offset;
		logic signed [15:0] read_value;
	} res_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

// ===== sv/rce_if.sv =====
interface rce_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] sample;
	logic [13:0]        delay;
	logic [14:0]        window;
	logic [13:0]        read_address;

	modport source (output valid, mode, sample, delay, window, read_address, input ready);
	modport sink (input valid, mode, sample, delay, window, read_address, output ready);
endinterface

interface rce_result_if;
	logic               valid;
	logic               ready;
	logic [13:0]        write_slot;
	logic               write_triggered;
	logic [14:0]        result_delay;
	logic               found;
	logic               single_shot_hit;
	logic [13:0]        trigger_offset;
	logic signed [15:0] read_value;

	modport source (output valid, write_slot, write_triggered, result_delay, found,
		single_shot_hit, trigger_offset, read_value, input ready);
	modport sink (input valid, write_slot, write_triggered, result_delay, found,
		single_shot_hit, trigger_offset, read_value, output ready);
endinterface

interface rce_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/rce_front.sv =====
module rce_front (
	input  logic          clk,
	input  logic          arst_n,
	rce_item_if.sink      items,
	output rce_pkg::head_t head,
	input  logic          pop
);

	rce_pkg::item_t q_mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	rce_pkg::op_t   op;

	assign items.ready = (count_q != 2'd2);
	assign push = items.valid && items.ready;

	always_comb begin
		unique case (items.mode)
			2'd0: op = rce_pkg::OP_WRITE;
			2'd1: op = rce_pkg::OP_SEARCH;
			2'd2: op = rce_pkg::OP_READ;
			2'd3: op = rce_pkg::OP_REARM;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q].op           <= op;
			q_mem_q[wr_ptr_q].sample       <= items.sample;
			q_mem_q[wr_ptr_q].delay        <= items.delay;
			q_mem_q[wr_ptr_q].window       <= items.window;
			q_mem_q[wr_ptr_q].read_address <= items.read_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assign head.valid = (count_q != 2'd0);
	assign head.item  = q_mem_q[rd_ptr_q];

endmodule

// ===== sv/rce_back.sv =====
module rce_back #(
	parameter int RING_DEPTH = 16384
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rce_pkg::head_t head,
	output logic           pop,
	rce_cfg_if.sink        cfg,
	rce_result_if.source   results
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int KW = (AW + 1 > 15) ? AW + 1 : 15;
	localparam int QN = 14 + AW;
	localparam longint unsigned RECIP =
		((64'd1 << QN) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
	localparam logic [15:0] RECIP_W = 16'(RECIP);
	localparam logic [13:0] DEPTH_LO = 14'(RING_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

	rce_pkg::state_t state_q, state_d;
	logic [AW-1:0]      newest_q;
	rce_pkg::seek_t     seek_q, seek_d;
	logic [1:0]         tmode_q;
	logic signed [15:0] level_q;
	logic signed [15:0] offset_q;
	logic [14:0]        hyst_q;
	logic               single_q;
	logic [AW-1:0]      clr_q;
	logic               res_valid_q;
	rce_pkg::res_t      res_q, res_d;
	logic               chk_v_s1;
	logic [KW-1:0]      chk_k_s1;
	logic               flag_s1;
	logic signed [15:0] rd_s1;
	logic [KW-1:0]      r_q;
	logic               step_q;
	logic [13:0]        qt_s1;
	rce_pkg::op_t       op_q;
	logic [13:0]        delay_q;
	logic [14:0]        window_q;
	logic [AW-1:0]      addr_q;
	logic [KW-1:0]      k_q;
	logic [KW-1:0]      limit_q;

	logic [15:0] smem [RING_DEPTH];
	logic        fmem [RING_DEPTH];

	logic               res_free;
	logic               take;
	logic               emit;
	logic               s_we, s_re, f_we, f_re;
	logic [AW-1:0]      f_wa;
	logic               f_wd;
	logic [AW-1:0]      slot_nx;
	logic               hit;
	logic signed [16:0] thr;
	logic signed [17:0] band_hi, band_lo;
	logic [29:0]        prod;
	logic [13:0]        qt_nx;
	logic [27:0]        qd_full;
	logic [KW-1:0]      r_nx;
	logic [AW-1:0]      r_slot;
	logic [AW:0]        start_wrap;
	logic [AW-1:0]      start_addr;
	logic [KW-1:0]      limit_nx;
	logic               walk_found, walk_none, walk_done, walk_adv;
	logic [KW-1:0]      slot_ext;
	logic [KW-1:0]      delay_sum;
	logic               trig_on;

	assign cfg.ready = 1'b1;
	assign res_free = !res_valid_q || results.ready;
	assign trig_on = (tmode_q != rce_pkg::TRIG_OFF);

	assign slot_nx = (newest_q == LAST_SLOT) ? '0 : newest_q + 1'b1;
	assign slot_ext = KW'(slot_nx);

	// edge check against the band around level plus offset
	always_comb begin
		thr     = 17'(level_q) + 17'(offset_q);
		band_hi = 18'(thr) + 18'($signed({1'b0, hyst_q}));
		band_lo = 18'(thr) - 18'($signed({1'b0, hyst_q}));
		hit     = 1'b0;
		seek_d  = seek_q;
		if (18'(head.item.sample) >= band_hi) begin
			hit = (seek_q == rce_pkg::SEEK_BELOW) && (tmode_q == rce_pkg::TRIG_RISING);
			seek_d = rce_pkg::SEEK_ABOVE;
		end else if (18'(head.item.sample) < band_lo) begin
			hit = (seek_q == rce_pkg::SEEK_ABOVE) && (tmode_q == rce_pkg::TRIG_FALLING);
			seek_d = rce_pkg::SEEK_BELOW;
		end
	end

	// mod ring depth: reciprocal quotient first, then subtract quotient times depth
	always_comb begin
		prod    = {16'd0, r_q[13:0]} * {14'd0, RECIP_W};
		qt_nx   = 14'(prod >> QN);
		qd_full = {14'd0, qt_s1} * {14'd0, DEPTH_LO};
		r_nx    = KW'(r_q[13:0] - qd_full[13:0]);
	end

	assign r_slot = r_q[AW-1:0];
	assign start_wrap = {1'b0, newest_q} + (AW+1)'(RING_DEPTH) - {1'b0, r_slot};
	assign start_addr = (newest_q >= r_slot) ? newest_q - r_slot : start_wrap[AW-1:0];
	assign limit_nx = (KW'(window_q) < KW'(RING_DEPTH)) ? KW'(window_q) : KW'(RING_DEPTH);

	assign walk_found = chk_v_s1 && flag_s1;
	assign walk_none  = !chk_v_s1 && (k_q >= limit_q);
	assign walk_done  = walk_found || walk_none;
	assign delay_sum  = KW'(delay_q) + chk_k_s1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rce_pkg::ST_CLEAR: begin
				if (clr_q == LAST_SLOT) state_d = rce_pkg::ST_IDLE;
			end
			rce_pkg::ST_IDLE: begin
				if (head.valid && res_free) begin
					unique case (head.item.op)
						rce_pkg::OP_WRITE:  state_d = rce_pkg::ST_IDLE;
						rce_pkg::OP_SEARCH: state_d = trig_on ? rce_pkg::ST_REDUCE : rce_pkg::ST_IDLE;
						rce_pkg::OP_READ:   state_d = rce_pkg::ST_REDUCE;
						rce_pkg::OP_REARM:  state_d = rce_pkg::ST_CLEAR;
					endcase
				end
			end
			rce_pkg::ST_REDUCE: begin
				if (!step_q)
					state_d = (op_q == rce_pkg::OP_READ) ? rce_pkg::ST_READ : rce_pkg::ST_START;
			end
			rce_pkg::ST_START:    state_d = rce_pkg::ST_WALK;
			rce_pkg::ST_WALK:     if (walk_done && res_free) state_d = rce_pkg::ST_IDLE;
			rce_pkg::ST_READ:     state_d = rce_pkg::ST_READ_OUT;
			rce_pkg::ST_READ_OUT: if (res_free) state_d = rce_pkg::ST_IDLE;
			default:              state_d = rce_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		take     = 1'b0;
		emit     = 1'b0;
		s_we     = 1'b0;
		s_re     = 1'b0;
		f_we     = 1'b0;
		f_re     = 1'b0;
		f_wa     = slot_nx;
		f_wd     = hit;
		walk_adv = 1'b0;
		res_d    = '0;
		unique case (state_q)
			rce_pkg::ST_CLEAR: begin
				f_we = 1'b1;
				f_wa = clr_q;
				f_wd = 1'b0;
			end
			rce_pkg::ST_IDLE: begin
				if (head.valid && res_free) begin
					take = 1'b1;
					unique case (head.item.op)
						rce_pkg::OP_WRITE: begin
							emit = 1'b1;
							s_we = 1'b1;
							f_we = trig_on;
							res_d.write_slot = slot_ext[13:0];
							res_d.write_triggered = trig_on && hit;
						end
						rce_pkg::OP_SEARCH: begin
							emit = !trig_on;
							res_d.result_delay = {1'b0, head.item.delay};
						end
						rce_pkg::OP_READ: ;
						rce_pkg::OP_REARM: emit = 1'b1;
					endcase
				end
			end
			rce_pkg::ST_WALK: begin
				if (walk_done) begin
					emit = res_free;
					res_d.found = walk_found;
					if (walk_found) begin
						res_d.trigger_offset = chk_k_s1[13:0];
						res_d.single_shot_hit = single_q;
						res_d.result_delay = single_q ? {1'b0, delay_q} : delay_sum[14:0];
					end else begin
						res_d.result_delay = {1'b0, delay_q};
					end
				end else begin
					walk_adv = 1'b1;
					f_re = 1'b1;
				end
			end
			rce_pkg::ST_READ: s_re = 1'b1;
			rce_pkg::ST_READ_OUT: begin
				emit = res_free;
				res_d.read_value = rd_s1;
			end
			default: ;
		endcase
	end

	assign pop = take;

	always_ff @(posedge clk) begin
		if (s_we) smem[slot_nx] <= head.item.sample;
		if (s_re) rd_s1 <= smem[r_slot];
	end

	always_ff @(posedge clk) begin
		if (f_we) fmem[f_wa] <= f_wd;
		if (f_re) flag_s1 <= fmem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (emit) res_q <= res_d;
		if (take) begin
			op_q     <= head.item.op;
			delay_q  <= head.item.delay;
			window_q <= head.item.window;
			r_q      <= (head.item.op == rce_pkg::OP_READ) ?
				KW'(head.item.read_address) : KW'(head.item.delay);
			step_q   <= 1'b1;
		end
		if (state_q == rce_pkg::ST_REDUCE) begin
			if (step_q) qt_s1 <= qt_nx;
			else r_q <= r_nx;
			step_q <= 1'b0;
		end
		if (state_q == rce_pkg::ST_START) begin
			addr_q  <= start_addr;
			limit_q <= limit_nx;
		end
		if (walk_adv) begin
			chk_k_s1 <= k_q;
			if (k_q < limit_q) addr_q <= (addr_q == '0) ? LAST_SLOT : addr_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rce_pkg::ST_CLEAR;
			newest_q    <= '0;
			seek_q      <= rce_pkg::SEEK_INVALID;
			tmode_q     <= rce_pkg::TRIG_OFF;
			level_q     <= '0;
			offset_q    <= '0;
			hyst_q      <= '0;
			single_q    <= 1'b0;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			chk_v_s1    <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					rce_pkg::CFG_TRIGGER_MODE:  tmode_q  <= cfg.data[1:0];
					rce_pkg::CFG_TRIGGER_LEVEL: level_q  <= cfg.data;
					rce_pkg::CFG_LEVEL_OFFSET:  offset_q <= cfg.data;
					rce_pkg::CFG_HYSTERESIS:    hyst_q   <= cfg.data[14:0];
					rce_pkg::CFG_SINGLE_SHOT:   single_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (emit) res_valid_q <= 1'b1;
			else if (results.ready) res_valid_q <= 1'b0;
			if (state_q == rce_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (take && head.item.op == rce_pkg::OP_WRITE) begin
				newest_q <= slot_nx;
				if (trig_on) seek_q <= seek_d;
			end
			if (take && head.item.op == rce_pkg::OP_REARM) begin
				seek_q <= rce_pkg::SEEK_INVALID;
				clr_q  <= '0;
			end
			if (state_q == rce_pkg::ST_START) begin
				k_q      <= '0;
				chk_v_s1 <= 1'b0;
			end
			if (walk_adv) begin
				chk_v_s1 <= (k_q < limit_q);
				if (k_q < limit_q) k_q <= k_q + 1'b1;
			end
		end
	end

	assign results.valid           = res_valid_q;
	assign results.write_slot      = res_q.write_slot;
	assign results.write_triggered = res_q.write_triggered;
	assign results.result_delay    = res_q.result_delay;
	assign results.found           = res_q.found;
	assign results.single_shot_hit = res_q.single_shot_hit;
	assign results.trigger_offset  = res_q.trigger_offset;
	assign results.read_value      = res_q.read_value;

endmodule

// ===== sv/ring_capture_edge_trigger.sv =====
// channel   dir   word
// items     in    mode, sample, delay, window, read_address
// results   out   write_slot, write_triggered, result_delay, found,
//                 single_shot_hit, trigger_offset, read_value
// cfg       in    index, data (always ready)
//
// Write, rearm and trigger-off search items finish in the idle state. Read: the slot
// reduction mod ring depth (quotient, then remainder), a sample memory read, the output.
// Search: the same reduction, a start step, then a walk that ends at a flagged slot at
// offset k or at the end of the window; the walk reads one flag slot a cycle.
// Reset and every rearm run a flag clearing pass over all RING_DEPTH slots; no item is
// started meanwhile and the two-word queue fills, then holds the input.
// A held result stalls the engine; the queue and output register part the sides.
module ring_capture_edge_trigger #(
	parameter int RING_DEPTH = 16384
) (
	input logic          clk,
	input logic          arst_n,
	rce_item_if.sink     items,
	rce_cfg_if.sink      cfg,
	rce_result_if.source results
);

	rce_pkg::head_t head;
	logic           pop;

	rce_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.head   (head),
		.pop    (pop)
	);

	rce_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.cfg     (cfg),
		.results (results)
	);

endmodule
